// ===== rtl/rtv_pkg.sv =====
// Package for the broadcast text validator: text length, index widths and
// the layout of one slot entry in the slot memory. No dependencies.
`default_nettype none

package rtv_pkg;

  localparam int TEXT_LEN = 8;
  localparam int ADDR_W = (TEXT_LEN > 1) ? $clog2(TEXT_LEN) : 1;
  localparam int POS_W = 6;
  localparam int CHAR_W = 8;
  localparam int CNT_W = 8;

  localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(TEXT_LEN - 1);
  localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(3);
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef struct packed {
    logic [CHAR_W-1:0] prim;
    logic [CHAR_W-1:0] alt;
    logic [CNT_W-1:0]  cnt;
  } entry_t;

endpackage

`default_nettype wire

// ===== rtl/rds_text_validator.sv =====
// Order: an accepted request updates its slot, then the whole slot memory is swept for the
// count check; the incomplete marker follows the sweep, or else the slots are read out in order.
// A position past the text skips the update. A new request is taken only once the previous
// one has finished; the single slot memory, walked once for the count check and once for
// emission, is what holds requests back.
// Reset: synchronous; all slots read as empty and the limit returns to 3.
`default_nettype none

module rds_text_validator (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [rtv_pkg::CNT_W-1:0]   confirm_limit,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [rtv_pkg::POS_W-1:0]   position,
  input  wire logic [rtv_pkg::CHAR_W-1:0]  character,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             complete,
  output logic [rtv_pkg::POS_W-1:0]        slot,
  output logic [rtv_pkg::CHAR_W-1:0]       glyph,
  output logic                             text_changed,
  output logic                             last
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_UPD  = 6'b000010,
    S_CHK  = 6'b000100,
    S_MARK = 6'b001000,
    S_ERD  = 6'b010000,
    S_ELD  = 6'b100000
  } state_t;

  state_t state, state_next;

  rtv_pkg::entry_t mem [rtv_pkg::TEXT_LEN];
  logic [rtv_pkg::TEXT_LEN-1:0] vld;
  rtv_pkg::entry_t rdata;
  logic rvalid;
  rtv_pkg::entry_t rd_entry;

  logic mem_we, mem_re;
  logic [rtv_pkg::ADDR_W-1:0] mem_wa, mem_ra;
  rtv_pkg::entry_t mem_wd;

  logic [rtv_pkg::CNT_W-1:0] lim;
  logic [rtv_pkg::ADDR_W-1:0] pos_q, pos_q_next;
  logic [rtv_pkg::CHAR_W-1:0] ch_q, ch_q_next;
  logic changed, changed_next;
  logic [rtv_pkg::ADDR_W-1:0] rd_idx, rd_idx_next;
  logic [rtv_pkg::ADDR_W-1:0] wb_idx, wb_idx_next;
  logic issue_done, issue_done_next;
  logic rd_pend, rd_pend_next;
  logic complete_ok, complete_ok_next;
  logic [rtv_pkg::ADDR_W-1:0] emit_idx, emit_idx_next;

  logic out_free, load;
  logic load_complete, load_last;
  logic [rtv_pkg::POS_W-1:0] load_slot;
  logic [rtv_pkg::CHAR_W-1:0] load_glyph;

  logic in_range;
  logic [rtv_pkg::CNT_W-1:0] lim1, dec_cnt;
  rtv_pkg::entry_t upd;
  logic upd_changed;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign out_free  = !out_valid || out_ready;
  assign rd_entry  = rvalid ? rdata : '0;
  assign in_range  = {1'b0, position} < 7'(rtv_pkg::TEXT_LEN);
  assign lim1      = (lim == rtv_pkg::CNT_MAX) ? rtv_pkg::CNT_MAX : lim + 8'd1;
  assign dec_cnt   = (changed && rd_entry.cnt > 8'd1) ? rd_entry.cnt - 8'd1 : rd_entry.cnt;

  always_comb begin
    upd = rd_entry;
    upd_changed = 1'b0;
    if (rd_entry.prim == ch_q) begin
      if (rd_entry.cnt < lim) begin
        upd.cnt = rd_entry.cnt + 8'd1;
      end else begin
        upd.cnt = lim;
        upd.alt = ch_q;
      end
    end else if (rd_entry.alt == ch_q) begin
      upd_changed = (rd_entry.cnt >= lim);
      upd.cnt = lim1;
      upd.alt = rd_entry.prim;
      upd.prim = ch_q;
    end else if (rd_entry.cnt == '0) begin
      upd.prim = ch_q;
      upd.cnt = 8'd1;
    end else begin
      upd.alt = ch_q;
    end
  end

  always_comb begin
    state_next = state;
    pos_q_next = pos_q;
    ch_q_next = ch_q;
    changed_next = changed;
    rd_idx_next = rd_idx;
    wb_idx_next = wb_idx;
    issue_done_next = issue_done;
    rd_pend_next = rd_pend;
    complete_ok_next = complete_ok;
    emit_idx_next = emit_idx;
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = '0;
    mem_re = 1'b0;
    mem_ra = '0;
    load = 1'b0;
    load_complete = 1'b0;
    load_slot = '0;
    load_glyph = '0;
    load_last = 1'b0;
    case (state)
      S_IDLE: begin
        rd_idx_next = '0;
        issue_done_next = 1'b0;
        rd_pend_next = 1'b0;
        complete_ok_next = 1'b1;
        if (in_valid) begin
          pos_q_next = position[rtv_pkg::ADDR_W-1:0];
          ch_q_next = character;
          changed_next = 1'b0;
          if (in_range) begin
            mem_re = 1'b1;
            mem_ra = position[rtv_pkg::ADDR_W-1:0];
            state_next = S_UPD;
          end else begin
            state_next = S_CHK;
          end
        end
      end
      S_UPD: begin
        mem_we = 1'b1;
        mem_wa = pos_q;
        mem_wd = upd;
        changed_next = upd_changed;
        state_next = S_CHK;
      end
      S_CHK: begin
        if (rd_pend) begin
          mem_we = changed;
          mem_wa = wb_idx;
          mem_wd = rd_entry;
          mem_wd.cnt = dec_cnt;
          complete_ok_next = complete_ok && (dec_cnt >= lim);
        end
        if (!issue_done) begin
          mem_re = 1'b1;
          mem_ra = rd_idx;
          rd_pend_next = 1'b1;
          wb_idx_next = rd_idx;
          if (rd_idx == rtv_pkg::LAST_IDX) begin
            issue_done_next = 1'b1;
          end else begin
            rd_idx_next = rd_idx + 1'b1;
          end
        end else begin
          rd_pend_next = 1'b0;
          if (rd_pend) begin
            state_next = complete_ok_next ? S_ERD : S_MARK;
          end
        end
      end
      S_MARK: begin
        if (out_free) begin
          load = 1'b1;
          load_last = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_ERD: begin
        mem_re = 1'b1;
        mem_ra = '0;
        emit_idx_next = '0;
        state_next = S_ELD;
      end
      S_ELD: begin
        if (out_free) begin
          load = 1'b1;
          load_complete = 1'b1;
          load_slot = rtv_pkg::POS_W'(emit_idx);
          load_glyph = rd_entry.prim;
          load_last = (emit_idx == rtv_pkg::LAST_IDX);
          if (emit_idx == rtv_pkg::LAST_IDX) begin
            state_next = S_IDLE;
          end else begin
            mem_re = 1'b1;
            mem_ra = emit_idx + 1'b1;
            emit_idx_next = emit_idx + 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      rvalid <= 1'b0;
    end else begin
      if (mem_we) begin
        vld[mem_wa] <= 1'b1;
      end
      if (mem_re) begin
        rvalid <= vld[mem_ra];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      lim <= rtv_pkg::LIMIT_RESET;
      out_valid <= 1'b0;
      changed <= 1'b0;
      issue_done <= 1'b0;
      rd_pend <= 1'b0;
      complete_ok <= 1'b1;
      rd_idx <= '0;
      wb_idx <= '0;
      emit_idx <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        lim <= confirm_limit;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      changed <= changed_next;
      issue_done <= issue_done_next;
      rd_pend <= rd_pend_next;
      complete_ok <= complete_ok_next;
      rd_idx <= rd_idx_next;
      wb_idx <= wb_idx_next;
      emit_idx <= emit_idx_next;
    end
  end

  always_ff @(posedge clk) begin
    pos_q <= pos_q_next;
    ch_q <= ch_q_next;
    if (load) begin
      complete <= load_complete;
      slot <= load_slot;
      glyph <= load_glyph;
      text_changed <= changed;
      last <= load_last;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("new request taken while the previous one is in progress");

  a_no_same_entry: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHK) && mem_we && mem_re |-> mem_wa != mem_ra)
    else $error("check sweep reads and writes the same slot in one cycle");

  a_emit_only_complete: assert property (@(posedge clk) disable iff (rst)
    (state == S_ELD) |-> complete_ok)
    else $error("emission started for incomplete text");

  a_marker_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && !complete |-> last && slot == '0 && glyph == '0)
    else $error("incomplete marker carries a character");

endmodule

`default_nettype wire
